FILE: hdl/pba_pkg.sv
`timescale 1ns / 1ps
package pba_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SRD,
        S_SLD,
        S_SBIT,
        S_MRD,
        S_MLD,
        S_MBIT,
        S_FIN
    } t_state;

    // Request modes.
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_ALIGN = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // Register indexes.
    localparam logic REG_PAGE_TOTAL   = 1'b0;
    localparam logic REG_FIRST_USABLE = 1'b1;

    localparam logic [12:0] PAGE_TOTAL_RST   = 13'd4096;
    localparam logic [11:0] FIRST_USABLE_RST = 12'd0;

    // Configuration seen by the controller.
    typedef struct packed {
        logic [12:0] page_total;
        logic [11:0] first_usable_page;
    } t_cfg;

endpackage

FILE: hdl/page_bitmap_allocator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// s_axis    in         tvalid/tready            request: length, alignment, page; tuser mode
// m_axis    out        tvalid/tready            status, granted page, used and free counts
// apb       in         psel/penable/pwrite      page_total at 0x0, first_usable_page at 0x4
//
// After reset a pass writes ones into all MAP_WORDS bitmap words (128 by default); no
// request is taken until it ends. One request is handled at a time.
// A search reads each bitmap word it enters and examines pages one by one in words
// holding a free page; fully used words are skipped at word granularity.
// Marking or freeing a run goes page by page, with one write per word touched, all as
// read-modify-write through the single write port of the bitmap memory. A result waits
// in the output register under back pressure while the next request is already accepted.
module page_bitmap_allocator #(
    parameter int MAX_PAGES     = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [12:0] run_length, [16:13] align_exponent, [28:17] page_number, [31:29] zero
    input  logic [31:0] i_s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] status, [13:2] granted_page, [26:14] used_count, [39:27] free_count
    output logic [39:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pba_pkg::*;

    localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WB = $clog2(MAP_WORD_BITS);
    localparam int PW = ($clog2(MAX_PAGES) + 2 > 14) ? $clog2(MAX_PAGES) + 2 : 14;
    localparam int UW = $clog2(MAX_PAGES + 1);
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [PW-1:0] MAX_P = PW'(MAX_PAGES);

    t_cfg w_cfg;

    pba_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Bitmap memory.
    logic                     w_we;
    logic [AW-1:0]            w_waddr, w_raddr;
    logic [MAP_WORD_BITS-1:0] w_wdata, w_rdata;

    pba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    t_state r_state, n_state;
    logic [PW-1:0]            r_p, n_p;
    logic [PW-1:0]            r_end, n_end;
    logic [PW-1:0]            r_mask, n_mask;
    logic [13:0]              r_run, n_run;
    logic [12:0]              r_len, n_len;
    logic                     r_mark, n_mark;
    logic [MAP_WORD_BITS-1:0] r_word, n_word;
    logic [UW-1:0]            r_used, n_used;
    logic [1:0]               r_status, n_status;
    logic [11:0]              r_granted, n_granted;
    logic [AW-1:0]            r_clr, n_clr;
    logic                     r_ovalid, n_ovalid;
    logic [39:0]              r_odata, n_odata;

    // Request fields.
    logic [1:0]  w_mode;
    logic [12:0] w_len;
    logic [3:0]  w_ex;
    logic [11:0] w_page;
    assign w_mode = i_s_axis_tuser;
    assign w_len  = i_s_axis_tdata[12:0];
    assign w_ex   = i_s_axis_tdata[16:13];
    assign w_page = i_s_axis_tdata[28:17];

    // Total in force and per-page helpers.
    logic [PW-1:0]            w_total, w_np, w_free_end, w_start, w_full;
    logic [PW-1:0]            w_amask;
    logic                     w_bit, w_last, w_bound, w_aligned;
    logic [MAP_WORD_BITS-1:0] w_mod;
    logic [PW-1:0]            w_free;

    assign w_total = (PW'(w_cfg.page_total) < MAX_P) ? PW'(w_cfg.page_total) : MAX_P;
    assign w_np    = r_p + PW'(1);
    assign w_bit   = r_word[r_p[WB-1:0]];
    assign w_last  = (w_np == r_end);
    assign w_bound = (w_np[WB-1:0] == '0);
    assign w_aligned = ((r_p & r_mask) == '0);
    assign w_start = w_np - PW'(r_len);
    assign w_full  = PW'(w_page) + PW'(w_len);
    assign w_free_end = (w_full < w_total) ? w_full : w_total;
    assign w_free  = (w_total > PW'(r_used)) ? w_total - PW'(r_used) : '0;

    // Alignment mask from the exponent.
    always_comb begin
        for (int k = 0; k < PW; k++) begin
            w_amask[k] = (int'(w_ex) > k);
        end
    end

    // Word with the current page bit set or cleared.
    always_comb begin
        w_mod = r_word;
        w_mod[r_p[WB-1:0]] = r_mark;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_clr    <= '0;
            r_used   <= UW'(MAX_PAGES);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_end     <= n_end;
        r_mask    <= n_mask;
        r_run     <= n_run;
        r_len     <= n_len;
        r_mark    <= n_mark;
        r_word    <= n_word;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_odata   <= n_odata;
    end

    // Sequencer: fill after reset; search, then read-modify-write of the run; a free skips the search.
    always_comb begin
        n_state   = r_state;
        n_p       = r_p;
        n_end     = r_end;
        n_mask    = r_mask;
        n_run     = r_run;
        n_len     = r_len;
        n_mark    = r_mark;
        n_word    = r_word;
        n_used    = r_used;
        n_status  = r_status;
        n_granted = r_granted;
        n_clr     = r_clr;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        w_we      = 1'b0;
        w_waddr   = r_p[WB +: AW];
        w_wdata   = w_mod;
        w_raddr   = r_p[WB +: AW];

        // The result leaves on its transfer.
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '1;
                n_clr   = r_clr + AW'(1);
                if (r_clr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_len     = w_len;
                    n_run     = '0;
                    n_granted = '0;
                    if (w_len == '0 || w_mode == MODE_RSVD ||
                        (w_mode == MODE_FREE && w_page == '0)) begin
                        n_status = ST_REFUSED;
                        n_state  = S_FIN;
                    end else if (w_mode == MODE_FREE) begin
                        n_status = ST_DONE;
                        n_p      = PW'(w_page);
                        n_end    = w_free_end;
                        n_mark   = 1'b0;
                        n_state  = (PW'(w_page) >= w_free_end) ? S_FIN : S_MRD;
                    end else begin
                        n_status = ST_NOFIT;
                        n_p      = PW'(w_cfg.first_usable_page);
                        n_mask   = (w_mode == MODE_ALIGN) ? w_amask : '0;
                        n_state  = S_SRD;
                    end
                end
            end
            S_SRD: begin
                n_state = (r_p >= w_total) ? S_FIN : S_SLD;
            end
            S_SLD: begin
                n_word = w_rdata;
                if (w_rdata == '1) begin
                    // Whole word used: the run breaks, go to the next word.
                    n_run   = '0;
                    n_p     = (r_p | PW'(MAP_WORD_BITS - 1)) + PW'(1);
                    n_state = S_SRD;
                end else begin
                    n_state = S_SBIT;
                end
            end
            S_SBIT: begin
                if (r_p >= w_total) begin
                    n_state = S_FIN;
                end else begin
                    n_p     = w_np;
                    n_state = w_bound ? S_SRD : S_SBIT;
                    if (w_bit) begin
                        n_run = '0;
                    end else if (r_run != '0 || w_aligned) begin
                        n_run = r_run + 14'd1;
                        if (r_run + 14'd1 == {1'b0, r_len}) begin
                            n_status  = ST_DONE;
                            n_granted = w_start[11:0];
                            n_p       = w_start;
                            n_end     = w_np;
                            n_mark    = 1'b1;
                            n_state   = S_MRD;
                        end
                    end
                end
            end
            S_MRD: begin
                n_state = S_MLD;
            end
            S_MLD: begin
                n_word  = w_rdata;
                n_state = S_MBIT;
            end
            S_MBIT: begin
                n_word = w_mod;
                if (r_mark && !w_bit) begin
                    n_used = r_used + UW'(1);
                end else if (!r_mark && w_bit) begin
                    n_used = r_used - UW'(1);
                end
                n_p = w_np;
                if (w_last || w_bound) begin
                    w_we = 1'b1;
                end
                if (w_last) begin
                    n_state = S_FIN;
                end else if (w_bound) begin
                    n_state = S_MRD;
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_odata  = {13'(w_free), 13'(r_used), r_granted, r_status};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: hdl/pba_ram.sv
`timescale 1ns / 1ps
module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/pba_apb.sv
`timescale 1ns / 1ps
module pba_apb (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output pba_pkg::t_cfg o_cfg
);
    import pba_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes in the access cycle of a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_total        <= PAGE_TOTAL_RST;
            r_cfg.first_usable_page <= FIRST_USABLE_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_PAGE_TOTAL:   r_cfg.page_total        <= pwdata[12:0];
                REG_FIRST_USABLE: r_cfg.first_usable_page <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (paddr[2])
            REG_PAGE_TOTAL:   prdata = {19'd0, r_cfg.page_total};
            REG_FIRST_USABLE: prdata = {20'd0, r_cfg.first_usable_page};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/pba_checker.sv
`timescale 1ns / 1ps
module pba_checker #(
    parameter int MAX_PAGES = 4096
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);
    import pba_pkg::*;

    // Status is always a defined code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] == ST_DONE ||
            o_m_axis_tdata[1:0] == ST_NOFIT || o_m_axis_tdata[1:0] == ST_REFUSED))
        else $error("undefined status");

    // A failed or refused request grants no page.
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[1:0] != ST_DONE) |-> o_m_axis_tdata[13:2] == '0)
        else $error("page granted without success");

    // Used and free together never exceed the page count.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ({1'b0, o_m_axis_tdata[26:14]} + {1'b0, o_m_axis_tdata[39:27]}) <= 14'(MAX_PAGES)
            || o_m_axis_tdata[39:27] == '0)
        else $error("counts out of range");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed under stall");

endmodule

bind page_bitmap_allocator pba_checker #(.MAX_PAGES(MAX_PAGES)) u_pba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import pba_pkg::*;

    localparam int NPAGES = 4096;
    localparam int STALL_LIMIT = 200000;
    localparam logic [2:0] ADDR_TOTAL = {REG_PAGE_TOTAL, 2'b00};
    localparam logic [2:0] ADDR_FIRST = {REG_FIRST_USABLE, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic [1:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        logic [1:0]  mode;
        logic [12:0] run_length;
        logic [3:0]  align_exp;
        logic [11:0] page_number;
    } t_request;

    // Packed from the highest bit down, so status lands in the lowest bits.
    typedef struct packed {
        logic [12:0] free_cnt;
        logic [12:0] used_cnt;
        logic [11:0] granted;
        logic [1:0]  status;
    } t_answer;

    // Bench copy of the allocator state and configuration.
    bit          page_map [NPAGES];
    int unsigned pages_in_use;
    int unsigned cfg_total;
    int unsigned cfg_first;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    int       errors;
    int       sent;
    int       answered;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;

    page_bitmap_allocator DUT (.*);

    // Clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit is_used(int unsigned p);
        if (p >= NPAGES) return 1'b1;
        return page_map[p];
    endfunction

    function automatic void claim_run(int unsigned start, int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            if (start + k < NPAGES && !page_map[start + k]) begin
                page_map[start + k] = 1'b1;
                pages_in_use++;
            end
        end
    endfunction

    // Computes the answer to one request and updates the bench state.
    function automatic t_answer allocate_request(t_request r);
        t_answer     a;
        int unsigned tot;
        int unsigned len;
        int unsigned run;
        int unsigned start;
        longint unsigned step;
        longint unsigned cand;
        bit          fits;
        tot = (cfg_total < NPAGES) ? cfg_total : NPAGES;
        len = 32'(r.run_length);
        a.status = ST_NOFIT;
        a.granted = '0;
        if (len == 0 || r.mode == MODE_RSVD ||
            (r.mode == MODE_FREE && r.page_number == 0)) begin
            a.status = ST_REFUSED;
        end else if (r.mode == MODE_FIRST) begin
            run = 0;
            start = 0;
            for (int unsigned p = cfg_first; p < tot; p++) begin
                if (!is_used(p)) begin
                    if (run == 0) start = p;
                    run++;
                    if (run == len) begin
                        claim_run(start, len);
                        a.status = ST_DONE;
                        a.granted = start[11:0];
                        break;
                    end
                end else begin
                    run = 0;
                end
            end
        end else if (r.mode == MODE_ALIGN) begin
            step = 64'd1 << r.align_exp;
            cand = (longint'(cfg_first) + step - 1) & ~(step - 1);
            for (; cand + len <= tot; cand += step) begin
                fits = 1'b1;
                for (int unsigned k = 0; k < len; k++) begin
                    if (is_used(32'(cand + k))) begin
                        fits = 1'b0;
                        break;
                    end
                end
                if (fits) begin
                    claim_run(32'(cand), len);
                    a.status = ST_DONE;
                    a.granted = cand[11:0];
                    break;
                end
            end
        end else begin
            for (int unsigned k = 0; k < len; k++) begin
                if (r.page_number + k < tot && page_map[r.page_number + k]) begin
                    page_map[r.page_number + k] = 1'b0;
                    pages_in_use--;
                end
            end
            a.status = ST_DONE;
        end
        a.used_cnt = pages_in_use[12:0];
        a.free_cnt = (tot > pages_in_use) ? 13'(tot - pages_in_use) : 13'd0;
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d expected %0d", answered, what, got, want);
        errors++;
    endtask

    // Driver: presents queued requests, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_answers.push_back(allocate_request(pending_reqs.pop_front()));
                sent++;
            end
            if ((!i_s_axis_tvalid || o_s_axis_tready) ) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {3'b0, pending_reqs[0].page_number,
                                       pending_reqs[0].align_exp, pending_reqs[0].run_length};
                    i_s_axis_tuser <= pending_reqs[0].mode;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and throttles the output side.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (expected_answers.size() == 0) begin
                    report_mismatch("transfer without request", 1, 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.granted !== want.granted)
                        report_mismatch("granted_page", got.granted, want.granted);
                    if (got.used_cnt !== want.used_cnt)
                        report_mismatch("used_count", got.used_cnt, want.used_cnt);
                    if (got.free_cnt !== want.free_cnt)
                        report_mismatch("free_count", got.free_cnt, want.free_cnt);
                end
                answered++;
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_TOTAL) cfg_total = 32'(value[12:0]);
        else cfg_first = 32'(value[11:0]);
    endtask

    function automatic t_request make_req(int m, int len, int ex, int pg);
        t_request r;
        r.mode = 2'(m);
        r.run_length = 13'(len);
        r.align_exp = 4'(ex);
        r.page_number = 12'(pg);
        return r;
    endfunction

    // Allocations are kept short most of the time so the map stays fragmented.
    function automatic t_request random_req();
        int kind;
        int len;
        kind = $urandom_range(99);
        if (kind < 3) len = $urandom_range(8191);
        else if (kind < 8) len = 0;
        else if (kind < 80) len = $urandom_range(1, 24);
        else len = $urandom_range(1, 400);
        kind = $urandom_range(99);
        if (kind < 40) return make_req(MODE_FIRST, len, $urandom_range(15), $urandom_range(4095));
        if (kind < 70) return make_req(MODE_ALIGN, len, $urandom_range(13) == 13 ?
                                       $urandom_range(15) : $urandom_range(6),
                                       $urandom_range(4095));
        if (kind < 97) return make_req(MODE_FREE, len, $urandom_range(15), $urandom_range(4095));
        return make_req(MODE_RSVD, len, $urandom_range(15), $urandom_range(4095));
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_answers.size() > 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        errors = 0;
        sent = 0;
        answered = 0;
        send_idle_pct = 34;
        recv_idle_pct = 52;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (page_map[k]) page_map[k] = 1'b1;
        pages_in_use = NPAGES;
        cfg_total = 32'(PAGE_TOTAL_RST);
        cfg_first = 32'(FIRST_USABLE_RST);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: refusals, failures on a full map, freeing past the total, extremes.
        pending_reqs.push_back(make_req(MODE_FIRST, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_FREE, 5, 0, 0));
        pending_reqs.push_back(make_req(MODE_RSVD, 5, 0, 7));
        pending_reqs.push_back(make_req(MODE_FIRST, 1, 0, 0));
        pending_reqs.push_back(make_req(MODE_FREE, 8191, 15, 4095));
        pending_reqs.push_back(make_req(MODE_FREE, 4095, 0, 1));
        pending_reqs.push_back(make_req(MODE_FIRST, 4096, 0, 0));
        pending_reqs.push_back(make_req(MODE_FIRST, 3, 0, 0));
        pending_reqs.push_back(make_req(MODE_ALIGN, 4, 12, 0));
        pending_reqs.push_back(make_req(MODE_ALIGN, 1, 15, 0));
        pending_reqs.push_back(make_req(MODE_ALIGN, 16, 4, 0));
        pending_reqs.push_back(make_req(MODE_ALIGN, 1, 0, 0));
        pending_reqs.push_back(make_req(MODE_FREE, 8191, 0, 2048));
        pending_reqs.push_back(make_req(MODE_ALIGN, 2048, 11, 0));
        pending_reqs.push_back(make_req(MODE_FIRST, 8191, 0, 0));
        pending_reqs.push_back(make_req(MODE_FREE, 4095, 0, 1));
        drain();

        // Small total with the first usable page past it, so searches find nothing; then extremes.
        reg_write(ADDR_TOTAL, 32'd100);
        reg_write(ADDR_FIRST, 32'd4095);
        pending_reqs.push_back(make_req(MODE_FIRST, 1, 0, 0));
        pending_reqs.push_back(make_req(MODE_FREE, 50, 0, 60));
        pending_reqs.push_back(make_req(MODE_ALIGN, 1, 0, 0));
        drain();
        reg_write(ADDR_TOTAL, 32'd0);
        reg_write(ADDR_FIRST, 32'd0);
        pending_reqs.push_back(make_req(MODE_FIRST, 1, 0, 0));
        pending_reqs.push_back(make_req(MODE_FREE, 3, 0, 1));
        drain();

        // Random phases under different settings and idling patterns.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin reg_write(ADDR_TOTAL, 32'd4096); reg_write(ADDR_FIRST, 32'd0); end
                1: begin reg_write(ADDR_TOTAL, 32'd8191); reg_write(ADDR_FIRST, 32'd37); end
                2: begin reg_write(ADDR_TOTAL, 32'd1000); reg_write(ADDR_FIRST, 32'd3); end
                3: begin reg_write(ADDR_TOTAL, 32'd4000); reg_write(ADDR_FIRST, 32'd4095); end
                4: begin reg_write(ADDR_TOTAL, 32'd3333); reg_write(ADDR_FIRST, 32'd512); end
                default: begin
                    reg_write(ADDR_TOTAL, 32'd4096);
                    reg_write(ADDR_FIRST, 32'd1);
                end
            endcase
            if (ph >= 2) begin
                send_idle_pct = 52;
                recv_idle_pct = 34;
            end
            if (ph >= 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 330; k++) pending_reqs.push_back(random_req());
            drain();
        end

        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pba_pkg.sv
hdl/pba_ram.sv
hdl/pba_apb.sv
hdl/page_bitmap_allocator.sv
hdl/pba_checker.sv
bench/tb.sv
